FILE: hw/rtl/btmx_pkg.sv
// btmx_pkg: types and constants of the max-xor binary trie block
// node word layout, operation and status codes, sequencer states
// no dependencies; imported by btmx_mem, btmx_walk and binary_trie_max_xor
package btmx_pkg;

	localparam int KEY_W     = 31;
	localparam int KEY_BITS  = 31;
	localparam int NODE_POOL = 8192;
	localparam int NODE_W    = $clog2(NODE_POOL);
	localparam int FREE_W    = NODE_W + 1;
	localparam int CNT_W     = 24;
	localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(KEY_BITS - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
	localparam logic [NODE_W-1:0] NULL_NODE = '0;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_ABSENT = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_CHK_END,
		ST_COMMIT,
		ST_COMMIT_END,
		ST_QRY,
		ST_QRY_END,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [CNT_W-1:0]  cnt;
	} node_t;

	typedef struct packed {
		logic [NODE_W-1:0] raddr_a;
		logic [NODE_W-1:0] raddr_b;
		logic              we;
		logic [NODE_W-1:0] waddr;
		node_t             wdata;
	} mem_req_t;

	typedef struct packed {
		stat_t            status;
		logic [KEY_W-1:0] best;
	} res_t;

endpackage

FILE: hw/rtl/binary_trie_max_xor.sv
// binary_trie_max_xor: top level of the max-xor binary trie block
// depends on btmx_pkg, btmx_mem and btmx_walk
//
// usage: a command item (kind, key) enters on cmd_valid/cmd_ready; kind
// inserts a key, deletes a key or asks for the largest key xor stored key.
// every command gives exactly one result item (status, best_xor) on
// rsp_valid/rsp_ready, in command order.
// one item at a time: cmd_ready is high only while the sequencer is idle.
// the sequencer walks one trie level per cycle; each level reads one node
// (two for a query) and a commit level also writes the updated node back;
// a query is one walk, an insert or delete is a check walk then a commit
// walk; a missing node or a bad count ends the check walk early.
// the result sits in an output register, so the next command is taken while
// a finished result waits; a stalled receiver holds the sequencer in its
// result state once that register is full.
// reset: the root pointers clear and the node counter returns to one; nodes
// are written when allocated, so the node memory needs no clearing pass and
// the block is ready straight after reset.
module binary_trie_max_xor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [1:0]                 kind,
	input  logic [btmx_pkg::KEY_W-1:0] key,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [1:0]                 status,
	output logic [btmx_pkg::KEY_W-1:0] best_xor
);
	import btmx_pkg::*;

	mem_req_t         req;
	node_t            rd_a;
	node_t            rd_b;
	logic             res_valid;
	logic             res_ready;
	res_t             res;

	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic [KEY_W-1:0] best_q;

	btmx_mem u_mem (
		.clk  (clk),
		.req  (req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	btmx_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.kind      (kind),
		.key       (key),
		.req       (req),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			status_q <= res.status;
			best_q   <= res.best;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign best_xor  = best_q;

endmodule

FILE: hw/rtl/btmx_mem.sv
// btmx_mem: node pool memory, one write port and two registered read ports
// depends on btmx_pkg for the node word and request types
module btmx_mem (
	input  logic              clk,
	input  btmx_pkg::mem_req_t req,
	output btmx_pkg::node_t   rd_a,
	output btmx_pkg::node_t   rd_b
);
	import btmx_pkg::*;

	node_t mem [NODE_POOL];
	node_t rd_a_q;
	node_t rd_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_a_q <= mem[req.raddr_a];
		rd_b_q <= mem[req.raddr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

FILE: hw/rtl/btmx_walk.sv
// btmx_walk: level-by-level trie walk sequencer with root pointers and free counter
// runs the check, commit and query walks over the node pool in btmx_mem
// depends on btmx_pkg
module btmx_walk (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [1:0]               kind,
	input  logic [btmx_pkg::KEY_W-1:0] key,
	output btmx_pkg::mem_req_t       req,
	input  btmx_pkg::node_t          rd_a,
	input  btmx_pkg::node_t          rd_b,
	output logic                     res_valid,
	input  logic                     res_ready,
	output btmx_pkg::res_t           res
);
	import btmx_pkg::*;

	state_t              state_q, state_d;
	logic [FREE_W-1:0]   next_free_q, next_free_d;
	logic [NODE_W-1:0]   root_l_q, root_l_d;
	logic [NODE_W-1:0]   root_r_q, root_r_d;

	logic [1:0]          kind_q, kind_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [LVL_W-1:0]    lvl_q, lvl_d;
	logic                first_q, first_d;
	logic                cur_new_q, cur_new_d;
	logic [NODE_W-1:0]   cur_idx_q, cur_idx_d;
	logic                want_null_q, want_null_d;
	logic                same_null_q, same_null_d;
	logic [KEY_W-1:0]    acc_q, acc_d;
	stat_t               status_q, status_d;

	node_t               root_w;
	logic                bit_k;
	logic                live_a;
	logic                live_b;
	logic                is_ins;
	logic [FREE_W-1:0]   need;
	logic [FREE_W-1:0]   avail;

	assign root_w = '{left: root_l_q, right: root_r_q, cnt: '0};
	assign bit_k  = key_q[lvl_q];
	assign live_a = !want_null_q && (rd_a.cnt != '0);
	assign live_b = !same_null_q && (rd_b.cnt != '0);
	assign is_ins = (kind_q == OP_INSERT);
	assign need   = FREE_W'(lvl_q) + FREE_W'(1);
	assign avail  = FREE_W'(NODE_POOL) - next_free_q;

	always_comb begin
		node_t             cur;
		node_t             upd;
		logic [NODE_W-1:0] ptr;
		logic [NODE_W-1:0] nx;
		logic [NODE_W-1:0] want;
		logic [NODE_W-1:0] same;

		state_d     = state_q;
		next_free_d = next_free_q;
		root_l_d    = root_l_q;
		root_r_d    = root_r_q;
		kind_d      = kind_q;
		key_d       = key_q;
		lvl_d       = lvl_q;
		first_d     = first_q;
		cur_new_d   = cur_new_q;
		cur_idx_d   = cur_idx_q;
		want_null_d = want_null_q;
		same_null_d = same_null_q;
		acc_d       = acc_q;
		status_d    = status_q;

		cur  = root_w;
		upd  = root_w;
		ptr  = NULL_NODE;
		nx   = NULL_NODE;
		want = NULL_NODE;
		same = NULL_NODE;

		req         = '0;
		req.waddr   = cur_idx_q;
		cmd_ready   = 1'b0;
		res_valid   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					kind_d   = kind;
					key_d    = key[KEY_BITS-1:0];
					lvl_d    = LVL_TOP;
					first_d  = 1'b1;
					acc_d    = '0;
					status_d = STAT_OK;
					case (kind)
						OP_INSERT, OP_DELETE: state_d = ST_CHK;
						OP_QUERY:             state_d = ST_QRY;
						default:              state_d = ST_RESP;
					endcase
				end
			end

			ST_CHK: begin
				cur = first_q ? root_w : rd_a;
				ptr = bit_k ? cur.right : cur.left;
				if (!first_q && is_ins && cur.cnt == CNT_MAX) begin
					status_d = STAT_FULL;
					state_d  = ST_RESP;
				end else if (!first_q && !is_ins && cur.cnt == '0) begin
					status_d = STAT_ABSENT;
					state_d  = ST_RESP;
				end else if (ptr == NULL_NODE) begin
					if (!is_ins) begin
						status_d = STAT_ABSENT;
						state_d  = ST_RESP;
					end else if (need > avail) begin
						status_d = STAT_FULL;
						state_d  = ST_RESP;
					end else begin
						lvl_d     = LVL_TOP;
						first_d   = 1'b1;
						cur_new_d = 1'b0;
						cur_idx_d = NULL_NODE;
						state_d   = ST_COMMIT;
					end
				end else begin
					req.raddr_a = ptr;
					first_d     = 1'b0;
					if (lvl_q == '0) begin
						state_d = ST_CHK_END;
					end else begin
						lvl_d = lvl_q - LVL_W'(1);
					end
				end
			end

			ST_CHK_END: begin
				if (is_ins && rd_a.cnt == CNT_MAX) begin
					status_d = STAT_FULL;
					state_d  = ST_RESP;
				end else if (!is_ins && rd_a.cnt == '0) begin
					status_d = STAT_ABSENT;
					state_d  = ST_RESP;
				end else begin
					lvl_d     = LVL_TOP;
					first_d   = 1'b1;
					cur_new_d = 1'b0;
					cur_idx_d = NULL_NODE;
					state_d   = ST_COMMIT;
				end
			end

			ST_COMMIT: begin
				cur = first_q ? root_w : (cur_new_q ? node_t'('0) : rd_a);
				upd = cur;
				upd.cnt = is_ins ? cur.cnt + CNT_W'(1) : cur.cnt - CNT_W'(1);
				ptr = bit_k ? cur.right : cur.left;
				nx  = ptr;
				cur_new_d = 1'b0;
				if (ptr == NULL_NODE) begin
					nx          = next_free_q[NODE_W-1:0];
					next_free_d = next_free_q + FREE_W'(1);
					cur_new_d   = 1'b1;
					if (bit_k) begin
						upd.right = nx;
					end else begin
						upd.left = nx;
					end
				end
				if (first_q) begin
					root_l_d = upd.left;
					root_r_d = upd.right;
				end else begin
					req.we    = 1'b1;
					req.wdata = upd;
				end
				req.raddr_a = nx;
				cur_idx_d   = nx;
				first_d     = 1'b0;
				if (lvl_q == '0) begin
					state_d = ST_COMMIT_END;
				end else begin
					lvl_d = lvl_q - LVL_W'(1);
				end
			end

			ST_COMMIT_END: begin
				cur = cur_new_q ? node_t'('0) : rd_a;
				upd = cur;
				upd.cnt = is_ins ? cur.cnt + CNT_W'(1) : cur.cnt - CNT_W'(1);
				req.we    = 1'b1;
				req.wdata = upd;
				status_d  = STAT_OK;
				state_d   = ST_RESP;
			end

			ST_QRY: begin
				if (!first_q && !live_a && !live_b) begin
					status_d = STAT_EMPTY;
					state_d  = ST_RESP;
				end else begin
					cur = first_q ? root_w : (live_a ? rd_a : rd_b);
					if (!first_q) begin
						acc_d = {acc_q[KEY_W-2:0], live_a};
					end
					want = bit_k ? cur.left : cur.right;
					same = bit_k ? cur.right : cur.left;
					req.raddr_a = want;
					req.raddr_b = same;
					want_null_d = (want == NULL_NODE);
					same_null_d = (same == NULL_NODE);
					first_d     = 1'b0;
					if (lvl_q == '0) begin
						state_d = ST_QRY_END;
					end else begin
						lvl_d = lvl_q - LVL_W'(1);
					end
				end
			end

			ST_QRY_END: begin
				if (!live_a && !live_b) begin
					status_d = STAT_EMPTY;
				end else begin
					acc_d    = {acc_q[KEY_W-2:0], live_a};
					status_d = STAT_OK;
				end
				state_d = ST_RESP;
			end

			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.status = status_q;
	assign res.best   = (status_q == STAT_OK) ? acc_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_free_q <= FREE_W'(1);
			root_l_q    <= NULL_NODE;
			root_r_q    <= NULL_NODE;
		end else begin
			state_q     <= state_d;
			next_free_q <= next_free_d;
			root_l_q    <= root_l_d;
			root_r_q    <= root_r_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q      <= kind_d;
		key_q       <= key_d;
		lvl_q       <= lvl_d;
		first_q     <= first_d;
		cur_new_q   <= cur_new_d;
		cur_idx_q   <= cur_idx_d;
		want_null_q <= want_null_d;
		same_null_q <= same_null_d;
		acc_q       <= acc_d;
		status_q    <= status_d;
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FREE_W'(NODE_POOL))
		else $error("node pool counter past pool size");

	a_free_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_COMMIT |=> $stable(next_free_q))
		else $error("node allocated outside commit walk");

	a_we_commit: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (state_q == ST_COMMIT || state_q == ST_COMMIT_END))
		else $error("node write outside commit walk");

	a_we_root: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (req.waddr != NULL_NODE && req.waddr != req.raddr_a))
		else $error("node write hits root or the node being read");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q != ST_IDLE)
		else $error("item accepted but sequencer stayed idle");

endmodule
